// ===== hdl/asfp_pkg.sv =====
// Package for the ASCII sensor frame parser.
// Holds the frame layout constants and the result record type; no dependencies.
package asfp_pkg;

  localparam logic [7:0]  AsciiZero   = 8'd48;
  localparam logic [11:0] HeaderLen   = 12'd4;
  localparam logic [11:0] PosMax      = 12'd4095;
  localparam logic [11:0] PosLength   = 12'd0;
  localparam logic [11:0] PosType     = 12'd1;
  localparam logic [11:0] PosPort     = 12'd2;
  localparam logic [11:0] PosDataLen  = 12'd3;

  typedef struct packed {
    logic [7:0]  stream_length;
    logic [7:0]  frame_type;
    logic [7:0]  port_number;
    logic [7:0]  data_length;
    logic [31:0] data_value;
    logic [31:0] checksum_value;
  } asfp_result_t;

endpackage

// ===== hdl/asfp_in_stage.sv =====
// Input register stage of the frame parser.
// Holds one character transfer until the parser takes it; uses asfp_pkg.
module asfp_in_stage import asfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       is_final_i,
  input  logic       out_busy_i,
  output logic       step_o,
  output logic [7:0] char_o,
  output logic       final_o
);

  logic       valid_q;
  logic [7:0] char_q;
  logic       final_q;

  // a final character waits while the result register is still occupied
  assign step_o     = valid_q && !(final_q && out_busy_i);
  assign in_ready_o = !valid_q || step_o;
  assign char_o     = char_q;
  assign final_o    = final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q  <= char_in_i;
      final_q <= is_final_i;
    end
  end

endmodule

// ===== hdl/asfp_parser.sv =====
// Frame state and field decode of the frame parser.
// Updates header, data and checksum registers per character; uses asfp_pkg.
module asfp_parser import asfp_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   char_i,
  input  logic         final_i,
  output asfp_result_t result_o
);

  logic [11:0]           pos_q, pos_d;
  logic [7:0]            length_q, length_d;
  logic [7:0]            type_q, type_d;
  logic [7:0]            port_q, port_d;
  logic [7:0]            dlen_q, dlen_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [31:0]           sum_q, sum_d;
  logic [7:0]            digit8;
  logic [31:0]           digit32;
  logic [11:0]           data_end;
  logic [31:0]           data32;

  assign digit8   = char_i - AsciiZero;
  assign digit32  = {24'd0, char_i} - 32'd48;
  assign data_end = HeaderLen + {1'b0, dlen_q, 3'b000};

  always_comb begin
    pos_d    = pos_q;
    length_d = length_q;
    type_d   = type_q;
    port_d   = port_q;
    dlen_d   = dlen_q;
    data_d   = data_q;
    sum_d    = sum_q;
    if (step_i) begin
      if (final_i) begin
        pos_d    = '0;
        length_d = '0;
        type_d   = '0;
        port_d   = '0;
        dlen_d   = '0;
        data_d   = '0;
        sum_d    = '0;
      end else begin
        if (pos_q == PosLength) begin
          length_d = digit8;
        end else if (pos_q == PosType) begin
          type_d = char_i;
        end else if (pos_q == PosPort) begin
          port_d = digit8;
        end else if (pos_q == PosDataLen) begin
          dlen_d = digit8;
        end else if (pos_q < data_end) begin
          data_d = {data_q[DATA_WIDTH-2:0], char_i[0]};
        end else begin
          sum_d = (sum_q << 3) + (sum_q << 1) + digit32;
        end
        if (pos_q != PosMax) begin
          pos_d = pos_q + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      length_q <= '0;
      type_q   <= '0;
      port_q   <= '0;
      dlen_q   <= '0;
      data_q   <= '0;
      sum_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      length_q <= length_d;
      type_q   <= type_d;
      port_q   <= port_d;
      dlen_q   <= dlen_d;
      data_q   <= data_d;
      sum_q    <= sum_d;
    end
  end

  generate
    if (DATA_WIDTH >= 32) begin : g_data_wide
      assign data32 = data_q[31:0];
    end else begin : g_data_narrow
      assign data32 = {{(32-DATA_WIDTH){1'b0}}, data_q};
    end
  endgenerate

  always_comb begin
    result_o.stream_length  = length_q;
    result_o.frame_type     = type_q;
    result_o.port_number    = port_q;
    result_o.data_length    = dlen_q;
    result_o.data_value     = data32;
    result_o.checksum_value = sum_q;
  end

endmodule

// ===== hdl/asfp_out_reg.sv =====
// Result register of the frame parser.
// Holds one frame result until it is transferred out; uses asfp_pkg.
module asfp_out_reg import asfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  asfp_result_t result_i,
  output logic         busy_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output asfp_result_t result_o
);

  logic         valid_q;
  asfp_result_t result_q;

  assign out_valid_o = valid_q;
  assign busy_o      = valid_q && !out_ready_i;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ===== hdl/ascii_sensor_frame_parser_core.sv =====
// ASCII sensor frame parser, top level.
// One character transfer per cycle sustained while no terminator waits on an
// occupied result register; each character is held in the input register and
// decoded into the frame registers, and a terminator loads the result register.
// Reset (asynchronous, active low) clears the frame state and both valid flags.
// Depends on asfp_pkg, asfp_in_stage, asfp_parser and asfp_out_reg.
module ascii_sensor_frame_parser_core import asfp_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  input  logic        is_final_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  stream_length_o,
  output logic [7:0]  frame_type_o,
  output logic [7:0]  port_number_o,
  output logic [7:0]  data_length_o,
  output logic [31:0] data_value_o,
  output logic [31:0] checksum_value_o
);

  logic         step;
  logic [7:0]   char_s;
  logic         final_s;
  logic         out_busy;
  asfp_result_t frame_res;
  asfp_result_t out_res;

  asfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_in_i  (char_in_i),
    .is_final_i (is_final_i),
    .out_busy_i (out_busy),
    .step_o     (step),
    .char_o     (char_s),
    .final_o    (final_s)
  );

  asfp_parser #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .char_i   (char_s),
    .final_i  (final_s),
    .result_o (frame_res)
  );

  asfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && final_s),
    .result_i    (frame_res),
    .busy_o      (out_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign stream_length_o  = out_res.stream_length;
  assign frame_type_o     = out_res.frame_type;
  assign port_number_o    = out_res.port_number;
  assign data_length_o    = out_res.data_length;
  assign data_value_o     = out_res.data_value;
  assign checksum_value_o = out_res.checksum_value;

endmodule

// ===== hdl/asfp_checker.sv =====
// Port-level checker for the frame parser, bound to the top level.
// Depends on ascii_sensor_frame_parser_core port names only.
module asfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        is_final_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] data_value_o,
  input logic [31:0] checksum_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(data_value_o) && $stable(checksum_value_o))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_result_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && is_final_i, 2))
    else $error("result without terminator transfer");

endmodule

bind ascii_sensor_frame_parser_core asfp_checker u_asfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .is_final_i       (is_final_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .data_value_o     (data_value_o),
  .checksum_value_o (checksum_value_o)
);
